>>> rtl/core/pwi_pkg.sv
// Shared constants and types for the windowed-integral PID controller.
`timescale 1ns / 1ps

package pwi_pkg;

    // Default depth of the error window.
    localparam int WINDOW_DEF = 16;

    // Field and register widths.
    localparam int ERR_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int OUT_W      = 32;
    localparam int MAX_W      = 31;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 31;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_P = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_D = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_I = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX    = 3'd4;

    // Control that travels with each request down the pipeline.
    typedef struct packed {
        logic valid;
        logic en;
    } pwi_ctl_t;

endpackage

>>> rtl/core/pwi_cell.sv
// One cell of the error window: holds one past error and passes it on.
`timescale 1ns / 1ps

module pwi_cell
    import pwi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    shift,
    input  logic signed [ERR_W-1:0] din,
    output logic signed [ERR_W-1:0] dout
);

    logic signed [ERR_W-1:0] err_reg;
    logic signed [ERR_W-1:0] err_next;

    // Take the neighbor's value on a shift, else hold.
    always_comb
    begin
        err_next = shift ? din : err_reg;
    end

    // The window starts out all zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg <= '0;
        end
        else
        begin
            err_reg <= err_next;
        end
    end

    assign dout = err_reg;

endmodule

>>> rtl/core/pwi_window.sv
// Error window chain, running window total, previous error and operand stage.
`timescale 1ns / 1ps

module pwi_window
    import pwi_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF,
    localparam int TOT_W = $clog2(WINDOW) + ERR_W
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    enable,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [ERR_W-1:0] in_err,
    output pwi_ctl_t                op_ctl,
    input  logic                    op_ready,
    output logic signed [ERR_W-1:0] op_err,
    output logic signed [ERR_W:0]   op_diff,
    output logic signed [TOT_W-1:0] op_total
);

    logic signed [ERR_W-1:0] tap [WINDOW];
    logic                    accept;
    logic                    shift;

    pwi_ctl_t                ctl_reg;
    pwi_ctl_t                ctl_next;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [ERR_W:0]   diff_reg;
    logic signed [ERR_W:0]   diff_next;
    logic signed [TOT_W-1:0] tot_snap_reg;
    logic signed [ERR_W-1:0] prev_reg;
    logic signed [ERR_W-1:0] prev_next;
    logic signed [TOT_W-1:0] total_reg;
    logic signed [TOT_W-1:0] total_next;

    // Handshake on the operand stage.
    assign in_ready = !ctl_reg.valid || op_ready;
    assign accept   = in_valid && in_ready;
    assign shift    = accept && enable;

    // Row of cells: the newest error enters cell 0, the oldest sits at the end.
    genvar g;
    generate
        for (g = 0; g < WINDOW; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                pwi_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .din   (in_err),
                    .dout  (tap[g])
                );
            end
            else
            begin : g_body
                pwi_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .din   (tap[g-1]),
                    .dout  (tap[g])
                );
            end
        end
    endgenerate

    // State update and operand capture.
    always_comb
    begin
        diff_next  = (ERR_W+1)'(in_err) - (ERR_W+1)'(prev_reg);
        prev_next  = shift ? in_err : prev_reg;
        total_next = shift ? total_reg + TOT_W'(in_err) - TOT_W'(tap[WINDOW-1])
                           : total_reg;
        ctl_next   = ctl_reg;
        if (accept)
        begin
            ctl_next.valid = 1'b1;
            ctl_next.en    = enable;
        end
        else if (op_ready)
        begin
            ctl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg   <= '0;
            prev_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            ctl_reg   <= ctl_next;
            prev_reg  <= prev_next;
            total_reg <= total_next;
        end
    end

    // Operand payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg      <= in_err;
            diff_reg     <= diff_next;
            tot_snap_reg <= total_reg;
        end
    end

    assign op_ctl   = ctl_reg;
    assign op_err   = err_reg;
    assign op_diff  = diff_reg;
    assign op_total = tot_snap_reg;

endmodule

>>> rtl/core/pwi_datapath.sv
// Product, sum and saturation stages with the result register.
`timescale 1ns / 1ps

module pwi_datapath
    import pwi_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF,
    localparam int TOT_W = $clog2(WINDOW) + ERR_W
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [GAIN_W-1:0] gain_p,
    input  logic signed [GAIN_W-1:0] gain_d,
    input  logic signed [GAIN_W-1:0] gain_i,
    input  logic [MAX_W-1:0]         max_output,
    input  pwi_ctl_t                 op_ctl,
    output logic                     op_ready,
    input  logic signed [ERR_W-1:0]  op_err,
    input  logic signed [ERR_W:0]    op_diff,
    input  logic signed [TOT_W-1:0]  op_total,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [OUT_W-1:0]         out_corr,
    output logic                     out_clamped
);

    localparam int P_W   = GAIN_W + ERR_W;
    localparam int D_W   = GAIN_W + ERR_W + 1;
    localparam int I_W   = GAIN_W + TOT_W;
    localparam int RAW_W = ((I_W > D_W) ? I_W : D_W) + 2;
    localparam int SUM_W = (RAW_W > OUT_W + 9) ? RAW_W : OUT_W + 9;
    localparam int VAL_W = SUM_W - 8;
    localparam logic signed [VAL_W-1:0] MinVal = VAL_W'(-64'sh8000_0000);

    pwi_ctl_t                ctl2_reg;
    pwi_ctl_t                ctl3_reg;
    pwi_ctl_t                ctl4_reg;
    logic                    rdy2;
    logic                    rdy3;
    logic                    rdy4;
    logic signed [P_W-1:0]   p_reg;
    logic signed [D_W-1:0]   d_reg;
    logic signed [I_W-1:0]   i_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [VAL_W-1:0] val;
    logic                    sat_hi;
    logic                    sat_lo;
    logic [OUT_W-1:0]        corr_reg;
    logic [OUT_W-1:0]        corr_next;
    logic                    clamp_reg;
    logic                    clamp_next;

    // A stage moves on when it is empty or the next one takes its request.
    assign rdy4     = !ctl4_reg.valid || out_ready;
    assign rdy3     = !ctl3_reg.valid || rdy4;
    assign rdy2     = !ctl2_reg.valid || rdy3;
    assign op_ready = rdy2;

    // Stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else
        begin
            if (rdy2)
            begin
                ctl2_reg <= op_ctl;
            end
            if (rdy3)
            begin
                ctl3_reg <= ctl2_reg;
            end
            if (rdy4)
            begin
                ctl4_reg <= ctl3_reg;
            end
        end
    end

    // Sum of the three terms, then floor shift by 8 and saturation; zero for a request taken while disabled.
    always_comb
    begin
        sum_next   = SUM_W'(p_reg) + SUM_W'(d_reg) + SUM_W'(i_reg);
        val        = $signed(sum_reg[SUM_W-1:8]);
        sat_hi     = val > $signed({{(VAL_W-MAX_W){1'b0}}, max_output});
        sat_lo     = val < MinVal;
        corr_next  = val[OUT_W-1:0];
        clamp_next = 1'b0;
        if (!ctl3_reg.en)
        begin
            corr_next = '0;
        end
        else if (sat_hi)
        begin
            corr_next  = {1'b0, max_output};
            clamp_next = 1'b1;
        end
        else if (sat_lo)
        begin
            corr_next  = MinVal[OUT_W-1:0];
            clamp_next = 1'b1;
        end
    end

    // Payload registers of the three stages.
    always_ff @(posedge clk)
    begin
        if (rdy2 && op_ctl.valid)
        begin
            p_reg <= gain_p * op_err;
            d_reg <= gain_d * op_diff;
            i_reg <= gain_i * op_total;
        end
        if (rdy3 && ctl2_reg.valid)
        begin
            sum_reg <= sum_next;
        end
        if (rdy4 && ctl3_reg.valid)
        begin
            corr_reg  <= corr_next;
            clamp_reg <= clamp_next;
        end
    end

    assign out_valid   = ctl4_reg.valid;
    assign out_corr    = corr_reg;
    assign out_clamped = clamp_reg;

endmodule

>>> rtl/core/pid_windowed_integral_top.sv
// Top level of the PID controller with a sliding-window integral term.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tdata[15:0] error_sample
// m_*       out        m_tvalid/m_tready  tdata[31:0] correction, tuser clamped
// cfg_*     in         cfg_we             cfg_addr index, cfg_wdata value
//
// One request per clock is accepted while s_tready is high; its result passes the
// operand, product, sum and result registers. The window state (cells, total,
// previous error) updates on accept while enabled, so requests follow each other
// without gaps. The four pipeline stages stall one by one from the output back;
// s_tready stays high while any stage is empty. rst_n clears the window at once.
//
module pid_windowed_integral_top
    import pwi_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [ERR_W-1:0]      s_tdata,    // [15:0] error_sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,    // [31:0] correction
    output logic                  m_tuser,    // [0] clamped
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int TOT_W = $clog2(WINDOW) + ERR_W;

    logic                     enable_reg;
    logic signed [GAIN_W-1:0] gain_p_reg;
    logic signed [GAIN_W-1:0] gain_d_reg;
    logic signed [GAIN_W-1:0] gain_i_reg;
    logic [MAX_W-1:0]         max_reg;

    pwi_ctl_t                 op_ctl;
    logic                     op_ready;
    logic signed [ERR_W-1:0]  op_err;
    logic signed [ERR_W:0]    op_diff;
    logic signed [TOT_W-1:0]  op_total;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            gain_p_reg <= '0;
            gain_d_reg <= '0;
            gain_i_reg <= '0;
            max_reg    <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_ENABLE: enable_reg <= cfg_wdata[0];
                CFG_GAIN_P: gain_p_reg <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_D: gain_d_reg <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_I: gain_i_reg <= cfg_wdata[GAIN_W-1:0];
                CFG_MAX:    max_reg    <= cfg_wdata[MAX_W-1:0];
                default:    ;
            endcase
        end
    end

    // Window state and operand stage.
    pwi_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .enable   (enable_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_err   ($signed(s_tdata)),
        .op_ctl   (op_ctl),
        .op_ready (op_ready),
        .op_err   (op_err),
        .op_diff  (op_diff),
        .op_total (op_total)
    );

    // Gain products, sum and saturation.
    pwi_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .gain_p      (gain_p_reg),
        .gain_d      (gain_d_reg),
        .gain_i      (gain_i_reg),
        .max_output  (max_reg),
        .op_ctl      (op_ctl),
        .op_ready    (op_ready),
        .op_err      (op_err),
        .op_diff     (op_diff),
        .op_total    (op_total),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_corr    (m_tdata),
        .out_clamped (m_tuser)
    );

endmodule

>>> rtl/core/pwi_checker.sv
// Port-level checks on the PID controller top level, bound to it.
`timescale 1ns / 1ps

module pwi_checker
    import pwi_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tuser
);

    localparam logic [2:0] Depth = 3'd4;

    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;

    // Requests inside the block: accepted minus delivered.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (s_tvalid && s_tready && !(m_tvalid && m_tready))
        begin
            cnt_next = cnt_reg + 3'd1;
        end
        else if (!(s_tvalid && s_tready) && m_tvalid && m_tready)
        begin
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // No result without an outstanding request, and never more than the stages hold.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= Depth) && ((cnt_reg != 3'd0) || !m_tvalid))
        else $error("result count out of step with requests");

    // The block takes requests while any stage is free.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg < Depth) |-> s_tready)
        else $error("input stalled with free stages");

    // A clamped value sits on a bound: the minimum or a non-negative limit.
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata == 32'h8000_0000) || !m_tdata[OUT_W-1])
        else $error("clamped value is not a bound");

endmodule

bind pid_windowed_integral_top pwi_checker u_pwi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
